// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared codes and control/status types of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

   // request kinds
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // memory read selection
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_HEAD = 2'd1;
   localparam logic [1:0] RD_TAIL = 2'd2;
   localparam logic [1:0] RD_NEXT = 2'd3;

   // memory write selection
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_ITEM  = 2'd1;
   localparam logic [1:0] WR_SHIFT = 2'd2;

   typedef struct packed {
      logic                load;
      logic [1:0]          rd_kind;
      logic [1:0]          wr_kind;
      logic                step;
      logic                ins_commit;
      logic                pop_commit;
      logic                set_res;
      logic [STATUS_W-1:0] res_code;
      logic                emit;
   } spq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic prio_ge;
      logic k_is_one;
      logic rsp_busy;
   } spq_stat_type;

endpackage

// ----- hw/rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for insert scan, pop and result hand-off
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_kind,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMP   = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_kind    = RD_NONE;
      cmd.wr_kind    = WR_NONE;
      cmd.res_code   = ST_INSERTED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_kind == CMD_POP) begin
                  if (stat.empty) begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = ST_EMPTY;
                     state_in     = S_DONE;
                  end else begin
                     cmd.rd_kind = RD_HEAD;
                     state_in    = S_POP;
                  end
               end else begin
                  if (stat.full) begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = ST_DROPPED;
                     state_in     = S_DONE;
                  end else if (stat.empty) begin
                     state_in = S_PLACE;
                  end else begin
                     cmd.rd_kind = RD_TAIL;
                     state_in    = S_CMP;
                  end
               end
            end
         end
         S_CMP: begin
            if (stat.prio_ge) begin
               cmd.wr_kind    = WR_ITEM;
               cmd.ins_commit = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.wr_kind = WR_SHIFT;
               cmd.step    = 1'b1;
               if (stat.k_is_one) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_kind = RD_NEXT;
               end
            end
         end
         S_PLACE: begin
            cmd.wr_kind    = WR_ITEM;
            cmd.ins_commit = 1'b1;
            state_in       = S_DONE;
         end
         S_POP: begin
            cmd.pop_commit = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/spq_dp.sv -----
// ----------------------------------------------------------------------------
// spq_dp
// entry memory as a ring in priority order, scan cursor and result registers
// ----------------------------------------------------------------------------
module spq_dp
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_cmd_type           cmd,
   output spq_stat_type          stat,
   input  logic [DATA_WIDTH-1:0] item_data,
   input  logic [PRIO_WIDTH-1:0] item_priority,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] out_data,
   output logic [PRIO_WIDTH-1:0] out_priority,
   output logic [STATUS_W-1:0]   status,
   output logic [OCC_W-1:0]      occupancy
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = DATA_WIDTH + PRIO_WIDTH;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                             input logic [CNT_W-1:0] j);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(h) + (CNT_W + 1)'(j);
      if (s >= (CNT_W + 1)'(CAPACITY)) begin
         s = s - (CNT_W + 1)'(CAPACITY);
      end
      return s[IDX_W-1:0];
   endfunction

   logic [ENTRY_W-1:0]    mem [CAPACITY];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [DATA_WIDTH-1:0] item_data_ff;
   logic [PRIO_WIDTH-1:0] item_prio_ff;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic [PRIO_WIDTH-1:0] res_prio_ff, res_prio_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [PRIO_WIDTH-1:0] rsp_prio_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [OCC_W-1:0]      rsp_occ_ff;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [DATA_WIDTH-1:0] rd_payload;
   logic [PRIO_WIDTH-1:0] rd_prio;

   assign rd_payload = rd_data_ff[DATA_WIDTH-1:0];
   assign rd_prio    = rd_data_ff[ENTRY_W-1:DATA_WIDTH];

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(CAPACITY));
   assign stat.prio_ge  = ($signed(rd_prio) >= $signed(item_prio_ff));
   assign stat.k_is_one = (k_ff == CNT_W'(1));
   assign stat.rsp_busy = rsp_valid_ff & ~rsp_ready;

   // memory ports
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = head_ff;
      case (cmd.rd_kind)
         RD_HEAD: rd_addr = head_ff;
         RD_TAIL: rd_addr = phys(head_ff, count_ff - CNT_W'(1));
         RD_NEXT: rd_addr = phys(head_ff, k_ff - CNT_W'(2));
         default: rd_en   = 1'b0;
      endcase
      wr_en   = (cmd.wr_kind == WR_ITEM) || (cmd.wr_kind == WR_SHIFT);
      wr_addr = phys(head_ff, k_ff);
      wr_data = (cmd.wr_kind == WR_SHIFT) ? rd_data_ff : {item_prio_ff, item_data_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // queue bookkeeping and result
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_prio_in   = res_prio_ff;
      if (cmd.load) begin
         k_in = count_ff;
      end else if (cmd.step) begin
         k_in = k_ff - CNT_W'(1);
      end
      if (cmd.set_res) begin
         res_status_in = cmd.res_code;
         res_data_in   = '0;
         res_prio_in   = '0;
      end
      if (cmd.ins_commit) begin
         count_in      = count_ff + CNT_W'(1);
         res_status_in = ST_INSERTED;
         res_data_in   = '0;
         res_prio_in   = '0;
      end
      if (cmd.pop_commit) begin
         count_in      = count_ff - CNT_W'(1);
         head_in       = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);
         res_status_in = ST_POPPED;
         res_data_in   = rd_payload;
         res_prio_in   = rd_prio;
      end
      rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_prio_ff   <= res_prio_in;
      if (cmd.load) begin
         item_data_ff <= item_data;
         item_prio_ff <= item_priority;
      end
      if (cmd.emit) begin
         rsp_data_ff   <= res_data_ff;
         rsp_prio_ff   <= res_prio_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign out_data     = rsp_data_ff;
   assign out_priority = rsp_prio_ff;
   assign status       = rsp_status_ff;
   assign occupancy    = rsp_occ_ff;

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept in descending priority order, one result per word
// ----------------------------------------------------------------------------
// Each request word gives exactly one response word. Entries sit in a single
// port-pair memory used as a ring with the head at the highest priority, so a
// pop reads the head entry directly, and a pop on an empty queue or an insert
// into a full queue goes straight to its result. An insert walks from the tail
// toward the head, moving one entry per cycle through the memory's one read
// and one write port, until it meets a stored entry of equal or higher
// priority. Equal priorities leave in arrival order. A new request is taken as
// soon as the previous result sits in the output register.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // item_data, item_priority, zero pad
   input  logic [((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_data, out_priority, occupancy, zero pad
   output logic [((DATA_WIDTH + PRIO_WIDTH + OCC_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int REQ_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + OCC_W + 7) / 8) * 8;

   spq_cmd_type           cmd;
   spq_stat_type          stat;
   logic [DATA_WIDTH-1:0] out_data;
   logic [PRIO_WIDTH-1:0] out_priority;
   logic [OCC_W-1:0]      occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .item_data     (req_tdata[DATA_WIDTH-1:0]),
      .item_priority (req_tdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH]),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .out_data      (out_data),
      .out_priority  (out_priority),
      .status        (rsp_tuser),
      .occupancy     (occupancy)
   );

   assign rsp_tdata = RSP_TDATA_W'({occupancy, out_priority, out_data});

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous word still in work");

   a_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_POPPED) |-> (out_data == '0 && out_priority == '0))
      else $error("non-pop response carries payload");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_EMPTY) |-> (occupancy == '0))
      else $error("empty pop with nonzero occupancy");

   a_drop_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_DROPPED) |-> (occupancy == OCC_W'(CAPACITY)))
      else $error("insert dropped while queue not full");
`endif

endmodule
